[sv/cba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

  localparam int FIRST_W = 10;
  localparam int LEN_W   = 11;
  localparam int GRANT_W = 10;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_REL_CHK,
    S_REL_LOOP,
    S_ALLOC_CHK,
    S_PRIME,
    S_SCAN,
    S_MARK_SET,
    S_MARK_LOOP,
    S_RESP_OK,
    S_RESP_FAIL,
    S_RESP_GRANT
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_SET_REL,
    OP_WRITE0,
    OP_SET_SCAN,
    OP_INC,
    OP_SCAN,
    OP_SET_MARK,
    OP_WRITE1,
    OP_RESP_OK,
    OP_RESP_FAIL,
    OP_RESP_GRANT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_LAST_ADDR,
    C_ACCEPT,
    C_RELEASE,
    C_REL_EMPTY,
    C_MARK_DONE,
    C_LEN_BAD,
    C_FOUND,
    C_EA_LAST,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
    step_t tgt_else;
  } ctrl_t;

  typedef struct packed {
    logic last_addr;
    logic accept;
    logic release_req;
    logic rel_empty;
    logic mark_done;
    logic len_bad;
    logic found;
    logic ea_last;
    logic out_free;
  } flags_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{OP_NONE, C_ALWAYS, S_IDLE, C_NEVER, S_IDLE, S_IDLE};
    case (s)
      S_INIT:       w = '{OP_INIT, C_LAST_ADDR, S_IDLE, C_NEVER, S_INIT, S_INIT};
      S_IDLE:       w = '{OP_LOAD, C_ACCEPT, S_DISPATCH, C_NEVER, S_IDLE, S_IDLE};
      S_DISPATCH:   w = '{OP_NONE, C_RELEASE, S_REL_CHK, C_NEVER, S_IDLE, S_ALLOC_CHK};
      S_REL_CHK:    w = '{OP_SET_REL, C_REL_EMPTY, S_RESP_OK, C_NEVER, S_IDLE, S_REL_LOOP};
      S_REL_LOOP:   w = '{OP_WRITE0, C_MARK_DONE, S_RESP_OK, C_NEVER, S_IDLE, S_REL_LOOP};
      S_ALLOC_CHK:  w = '{OP_SET_SCAN, C_LEN_BAD, S_RESP_FAIL, C_NEVER, S_IDLE, S_PRIME};
      S_PRIME:      w = '{OP_INC, C_ALWAYS, S_SCAN, C_NEVER, S_IDLE, S_SCAN};
      S_SCAN:       w = '{OP_SCAN, C_FOUND, S_MARK_SET, C_EA_LAST, S_RESP_FAIL, S_SCAN};
      S_MARK_SET:   w = '{OP_SET_MARK, C_ALWAYS, S_MARK_LOOP, C_NEVER, S_IDLE, S_MARK_LOOP};
      S_MARK_LOOP:  w = '{OP_WRITE1, C_MARK_DONE, S_RESP_GRANT, C_NEVER, S_IDLE, S_MARK_LOOP};
      S_RESP_OK:    w = '{OP_RESP_OK, C_OUT_FREE, S_IDLE, C_NEVER, S_IDLE, S_RESP_OK};
      S_RESP_FAIL:  w = '{OP_RESP_FAIL, C_OUT_FREE, S_IDLE, C_NEVER, S_IDLE, S_RESP_FAIL};
      S_RESP_GRANT: w = '{OP_RESP_GRANT, C_OUT_FREE, S_IDLE, C_NEVER, S_IDLE, S_RESP_GRANT};
      default:      w = '{OP_NONE, C_ALWAYS, S_IDLE, C_NEVER, S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[sv/cba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module cba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/cba_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module cba_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cba_pkg::flags_t flags,
  output cba_pkg::ctrl_t       ctrl
);
  import cba_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  hit_a;
  logic  hit_b;

  function automatic logic test(input cond_t c, input flags_t f);
    logic r;
    r = 1'b0;
    case (c)
      C_NEVER:     r = 1'b0;
      C_ALWAYS:    r = 1'b1;
      C_LAST_ADDR: r = f.last_addr;
      C_ACCEPT:    r = f.accept;
      C_RELEASE:   r = f.release_req;
      C_REL_EMPTY: r = f.rel_empty;
      C_MARK_DONE: r = f.mark_done;
      C_LEN_BAD:   r = f.len_bad;
      C_FOUND:     r = f.found;
      C_EA_LAST:   r = f.ea_last;
      C_OUT_FREE:  r = f.out_free;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  assign ctrl  = ucode(pc);
  assign hit_a = test(ctrl.cond_a, flags);
  assign hit_b = test(ctrl.cond_b, flags);

  always_comb begin
    if (hit_a) begin
      pc_next = ctrl.tgt_a;
    end else if (hit_b) begin
      pc_next = ctrl.tgt_b;
    end else begin
      pc_next = ctrl.tgt_else;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

[sv/contiguous_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator over a one-bit used/free map of NUM_BLOCKS blocks, held in a
// single-port-write RAM and driven by a small microcoded sequencer. After reset an
// init pass writes the map, one block a cycle, marking the first RESERVED_BLOCKS
// blocks used and the rest free; req_stall stays high meanwhile. For an allocate,
// the map is scanned one block per cycle through the RAM read port from block 0
// until a fitting run is found or the last block is passed, then the run is marked
// one block per cycle. A release clears its run, one block written per cycle. One
// request is handled at a time; a finished result waits in the output register.
module contiguous_block_allocator #(
  parameter int NUM_BLOCKS      = 1024,
  parameter int RESERVED_BLOCKS = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic                        mode,
  input  wire logic [cba_pkg::FIRST_W-1:0] first_block,
  input  wire logic [cba_pkg::LEN_W-1:0]   run_length,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic                             success,
  output logic      [cba_pkg::GRANT_W-1:0] granted_block
);
  import cba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int XW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

  ctrl_t  ctrl;
  flags_t flags;

  logic               mode_r;
  logic [FIRST_W-1:0] first_r;
  logic [LEN_W-1:0]   len_r;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      addr_next;
  logic [AW-1:0]      ea;
  logic [AW-1:0]      start;
  logic [LEN_W-1:0]   run;
  logic [LEN_W-1:0]   remain;
  logic               we;
  logic               wdata;
  logic               rdata;
  logic               out_free;
  logic               accept;
  logic               rsp_load;

  cba_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  cba_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign req_stall = (ctrl.op != OP_LOAD);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = out_free && (ctrl.op inside {OP_RESP_OK, OP_RESP_FAIL, OP_RESP_GRANT});
  assign addr_next = (addr == AW'(NUM_BLOCKS - 1)) ? '0 : addr + 1'b1;

  always_comb begin
    we    = 1'b0;
    wdata = 1'b0;
    case (ctrl.op)
      OP_INIT: begin
        we    = 1'b1;
        wdata = XW'(addr) < XW'(RESERVED_BLOCKS);
      end
      OP_WRITE0: begin
        we    = 1'b1;
        wdata = 1'b0;
      end
      OP_WRITE1: begin
        we    = 1'b1;
        wdata = 1'b1;
      end
      default: begin
        we    = 1'b0;
        wdata = 1'b0;
      end
    endcase
  end

  always_comb begin
    flags.last_addr   = (addr == AW'(NUM_BLOCKS - 1));
    flags.accept      = accept;
    flags.release_req = mode_r;
    flags.rel_empty   = (XW'(first_r) >= XW'(NUM_BLOCKS)) || (len_r == '0);
    flags.mark_done   = (remain == LEN_W'(1)) || (addr == AW'(NUM_BLOCKS - 1));
    flags.len_bad     = (len_r == '0) || (XW'(len_r) > XW'(NUM_BLOCKS));
    flags.found       = !rdata && (LEN_W'(run + 1'b1) == len_r);
    flags.ea_last     = (ea == AW'(NUM_BLOCKS - 1));
    flags.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    ea <= addr;
    if (rst) begin
      addr      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_INIT: begin
          addr <= addr_next;
        end
        OP_LOAD: begin
          if (accept) begin
            mode_r  <= mode;
            first_r <= first_block;
            len_r   <= run_length;
          end
        end
        OP_SET_REL: begin
          addr   <= AW'(first_r);
          remain <= len_r;
        end
        OP_WRITE0, OP_WRITE1: begin
          addr   <= addr_next;
          remain <= remain - 1'b1;
        end
        OP_SET_SCAN: begin
          addr <= '0;
          run  <= '0;
        end
        OP_INC: begin
          addr <= addr_next;
        end
        OP_SCAN: begin
          addr <= addr_next;
          if (!rdata) begin
            if (run == '0) begin
              start <= ea;
            end
            run <= run + 1'b1;
          end else begin
            run <= '0;
          end
        end
        OP_SET_MARK: begin
          addr   <= start;
          remain <= len_r;
        end
        OP_RESP_OK: begin
          if (out_free) begin
            success       <= 1'b1;
            granted_block <= '0;
          end
        end
        OP_RESP_FAIL: begin
          if (out_free) begin
            success       <= 1'b0;
            granted_block <= '0;
          end
        end
        OP_RESP_GRANT: begin
          if (out_free) begin
            success       <= 1'b1;
            granted_block <= GRANT_W'(start);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/cba_tb_pkg.sv]
`timescale 1ns / 1ps
package cba_tb_pkg;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_op_t;

endpackage

[tb/contiguous_block_allocator_checker.sv]
`timescale 1ns / 1ps
module contiguous_block_allocator_checker #(
  parameter int NUM_BLOCKS      = 1024,
  parameter int RESERVED_BLOCKS = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic                        mode,
  input  logic [cba_pkg::FIRST_W-1:0] first_block,
  input  logic [cba_pkg::LEN_W-1:0]   run_length,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic                        success,
  input  logic [cba_pkg::GRANT_W-1:0] granted_block,
  output int                          errors,
  output int                          pending
);
  import cba_tb_pkg::*;

  typedef struct packed {
    logic                        ok;
    logic [cba_pkg::GRANT_W-1:0] start;
  } grant_t;

  bit     block_busy [NUM_BLOCKS];
  grant_t grants_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void paint(int unsigned start, int unsigned len, bit val);
    int unsigned stop;
    if (start >= NUM_BLOCKS) return;
    stop = start + len;
    if (stop > NUM_BLOCKS) stop = NUM_BLOCKS;
    for (int unsigned b = start; b < stop; b++) block_busy[b] = val;
  endfunction

  // first-fit over the used map; updates the map as the block would
  function automatic grant_t serve(req_op_t op, logic [cba_pkg::FIRST_W-1:0] fb,
                                   logic [cba_pkg::LEN_W-1:0] len);
    grant_t      g;
    int unsigned run;
    int unsigned base;
    g    = '0;
    run  = 0;
    base = 0;
    if (op == REQ_FREE) begin
      paint(32'(fb), 32'(len), 1'b0);
      g.ok = 1'b1;
      return g;
    end
    if (len == 0 || len > NUM_BLOCKS) return g;
    for (int unsigned b = 0; b < NUM_BLOCKS; b++) begin
      if (!block_busy[b]) begin
        if (run == 0) base = b;
        run++;
        if (run == 32'(len)) begin
          paint(base, 32'(len), 1'b1);
          g.ok    = 1'b1;
          g.start = base[cba_pkg::GRANT_W-1:0];
          return g;
        end
      end else begin
        run = 0;
      end
    end
    return g;
  endfunction

  function automatic void mismatch(string field, int want, int got);
    if (errors < 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    errors++;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) block_busy[i] = (i < RESERVED_BLOCKS);
      grants_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (grants_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected item: success %0b granted_block %0d",
                     $realtime, success, granted_block);
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (success !== want.ok) mismatch("success", 32'(want.ok), 32'(success));
          if (granted_block !== want.start)
            mismatch("granted_block", 32'(want.start), 32'(granted_block));
        end
      end
      if (req_valid && !req_stall)
        grants_due.push_back(serve(req_op_t'(mode), first_block, run_length));
    end
    pending = grants_due.size();
  end

endmodule

[tb/contiguous_block_allocator_tb.sv]
`timescale 1ns / 1ps
module contiguous_block_allocator_tb;
  import cba_pkg::*;
  import cba_tb_pkg::*;

  localparam int NUM_BLOCKS      = 1024;
  localparam int RESERVED_BLOCKS = 1;
  localparam int RANDOM_ITEMS    = 580;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 64;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        req_valid   = 1'b0;
  logic                        mode        = 1'b0;
  logic [cba_pkg::FIRST_W-1:0] first_block = '0;
  logic [cba_pkg::LEN_W-1:0]   run_length  = '0;
  logic                        rsp_stall   = 1'b0;
  logic                        req_stall;
  logic                        rsp_valid;
  logic                        success;
  logic [cba_pkg::GRANT_W-1:0] granted_block;
  int                          errors;
  int                          pending;
  bit                          calm        = 1'b1;
  int                          stall_left  = 0;
  int                          idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  contiguous_block_allocator #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .first_block   (first_block),
    .run_length    (run_length),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .success       (success),
    .granted_block (granted_block)
  );

  contiguous_block_allocator_checker #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .first_block   (first_block),
    .run_length    (run_length),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .success       (success),
    .granted_block (granted_block),
    .errors        (errors),
    .pending       (pending)
  );

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic issue(req_op_t op, logic [cba_pkg::FIRST_W-1:0] fb,
                       logic [cba_pkg::LEN_W-1:0] len);
    int gap;
    mode        <= op;
    first_block <= fb;
    run_length  <= len;
    req_valid   <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (calm || $urandom_range(0, 2) == 0) gap = 0;
    else gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [cba_pkg::LEN_W-1:0] alloc_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return LEN_W'($urandom_range(NUM_BLOCKS + 1, 2047));
    if (r < 10) return LEN_W'($urandom_range(100, NUM_BLOCKS));
    return LEN_W'($urandom_range(1, 32));
  endfunction

  function automatic logic [cba_pkg::LEN_W-1:0] free_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return LEN_W'($urandom_range(0, 2047));
    if (r < 8) return '0;
    return LEN_W'($urandom_range(1, 64));
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(REQ_ALLOC, 0, 0);
    issue(REQ_ALLOC, 1023, 1);
    issue(REQ_ALLOC, 0, LEN_W'(NUM_BLOCKS));
    issue(REQ_ALLOC, 0, 2047);
    issue(REQ_ALLOC, 0, LEN_W'(NUM_BLOCKS - 2));
    issue(REQ_ALLOC, 0, 1);
    issue(REQ_FREE, 1023, 2047);
    issue(REQ_ALLOC, 0, 1);
    issue(REQ_FREE, 0, 0);
    issue(REQ_FREE, 0, LEN_W'(NUM_BLOCKS));
    issue(REQ_ALLOC, 0, LEN_W'(NUM_BLOCKS));
    issue(REQ_FREE, 512, 512);
    issue(REQ_ALLOC, 0, 513);
    issue(REQ_ALLOC, 0, 512);
    issue(REQ_FREE, 0, 2047);
    issue(REQ_FREE, 100, 10);
    issue(REQ_ALLOC, 0, 3);
    issue(REQ_FREE, 1, 1);
    issue(REQ_ALLOC, 0, 2);
    issue(REQ_ALLOC, 0, 1);
    issue(REQ_FREE, 1023, 1);
    issue(REQ_ALLOC, 0, LEN_W'(NUM_BLOCKS));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 55)
        issue(REQ_ALLOC, FIRST_W'($urandom_range(0, 1023)), alloc_len());
      else
        issue(REQ_FREE, FIRST_W'($urandom_range(0, 1023)), free_len());
    end

    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
sv/cba_pkg.sv
sv/cba_ram.sv
sv/cba_seq.sv
sv/contiguous_block_allocator.sv
tb/cba_tb_pkg.sv
tb/contiguous_block_allocator_checker.sv
tb/contiguous_block_allocator_tb.sv
